/* design/khm_pkg.sv */
// ============================================================================
// khm_pkg: key to HID event mapper shared definitions
// Sizes, table layout, codes and the control/status bundles between the
// controller and the datapath.
// ============================================================================
`default_nettype none

package khm_pkg;

    // Table geometry
    localparam int NUM_KEYS        = 8;
    localparam int ROW_BYTES       = 12;
    localparam int MAX_MACRO_CODES = 10;
    localparam int TABLE_SIZE      = NUM_KEYS * ROW_BYTES;
    localparam int ADDR_W          = $clog2(TABLE_SIZE);
    localparam int OFF_W           = $clog2(ROW_BYTES);
    localparam int MACRO_CAP       = (MAX_MACRO_CODES < ROW_BYTES - 2) ?
                                     MAX_MACRO_CODES : ROW_BYTES - 2;
    localparam int CNT_W           = $clog2(MACRO_CAP + 1);

    // Field widths fixed by the item format
    localparam int KEY_W      = 3;
    localparam int TADDR_W    = 7;
    localparam int BYTE_W     = 8;
    localparam int LED_W      = 8;
    localparam int LEDS_W     = 64;
    localparam int REPORT_N   = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 80;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_LED_MAX  = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_LED_GLOW = 1'd1;

    localparam logic [LED_W-1:0] LED_MAX_RESET  = 8'd127;
    localparam logic [LED_W-1:0] LED_GLOW_RESET = 8'd1;

    // Key types in row byte 0
    localparam logic [BYTE_W-1:0] KEYBOARD = 8'd0;
    localparam logic [BYTE_W-1:0] CONSUMER = 8'd1;
    localparam logic [BYTE_W-1:0] MACRO    = 8'd2;

    // Row byte offsets
    localparam logic [OFF_W-1:0] OFF_TYPE      = OFF_W'(0);
    localparam logic [OFF_W-1:0] OFF_KBD0_MOD  = OFF_W'(1);
    localparam logic [OFF_W-1:0] OFF_KBD0_CODE = OFF_W'(2);
    localparam logic [OFF_W-1:0] OFF_KBD1_MOD  = OFF_W'(3);
    localparam logic [OFF_W-1:0] OFF_KBD1_CODE = OFF_W'(4);
    localparam logic [OFF_W-1:0] OFF_CONS0     = OFF_W'(1);
    localparam logic [OFF_W-1:0] OFF_CONS1     = OFF_W'(2);
    localparam logic [OFF_W-1:0] OFF_COUNT     = OFF_W'(1);
    localparam logic [OFF_W-1:0] OFF_MACRO0    = OFF_W'(2);
    localparam logic [OFF_W-1:0] OFF_MACRO_NXT = OFF_W'(3);

    typedef enum logic [1:0] {
        REQ_KEY   = 2'd0,
        REQ_WRITE = 2'd1,
        REQ_FADE  = 2'd2
    } req_type_t;

    typedef enum logic [2:0] {
        EV_KBD_PRESS    = 3'd0,
        EV_KBD_RELEASE  = 3'd1,
        EV_CONS_PRESS   = 3'd2,
        EV_CONS_RELEASE = 3'd3,
        EV_LED_REPORT   = 3'd4
    } event_kind_t;

    typedef enum logic [1:0] {
        TC_KEYBOARD,
        TC_CONSUMER,
        TC_MACRO,
        TC_OTHER
    } type_class_t;

    typedef enum logic [2:0] {
        RD_TYPE,
        RD_KBD_MOD,
        RD_KBD_CODE,
        RD_CONS_CODE,
        RD_COUNT,
        RD_MACRO_FIRST,
        RD_MACRO_NEXT
    } rd_sel_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_TYPE,
        S_MOD,
        S_EMIT_KBD,
        S_EMIT_CONS,
        S_CNT,
        S_MPRESS,
        S_MREL,
        S_LED
    } state_t;

    typedef struct packed {
        logic        ld_item;
        logic        tbl_wr;
        logic        upd_key;
        logic        rd_en;
        rd_sel_t     rd_sel;
        logic        ld_mod;
        logic        ld_cnt;
        logic        inc_j;
        logic        emit;
        event_kind_t kind;
        logic        zero_mod;
        logic        last;
        logic        flip;
        logic        fade;
    } khm_cmd_t;

    typedef struct packed {
        req_type_t   req;
        logic        key_ok;
        logic        changed;
        logic        cur;
        type_class_t tclass;
        logic        cnt_zero;
        logic        j_last;
        logic        out_free;
    } khm_stat_t;

endpackage

`default_nettype wire

/* design/khm_ram.sv */
// ============================================================================
// khm_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle; read data holds between reads.
// ============================================================================
`default_nettype none

module khm_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 96
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

/* design/khm_ctrl.sv */
// ============================================================================
// khm_ctrl: sequencer of the key to HID event mapper
// Walks one item through table reads and beats; one step a cycle, bar stalls.
// ============================================================================
`default_nettype none

module khm_ctrl (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    output logic                    s_tready,
    input  wire khm_pkg::khm_stat_t stat,
    output khm_pkg::khm_cmd_t       cmd
);

    khm_pkg::state_t state_reg;
    khm_pkg::state_t state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= khm_pkg::S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        unique case (state_reg)
            khm_pkg::S_IDLE:
            begin
                s_tready = 1'b1;
                if (s_tvalid)
                begin
                    cmd.ld_item = 1'b1;
                    state_next  = khm_pkg::S_DISPATCH;
                end
            end
            khm_pkg::S_DISPATCH:
            begin
                state_next = khm_pkg::S_IDLE;
                unique case (stat.req)
                    khm_pkg::REQ_WRITE:
                    begin
                        cmd.tbl_wr = 1'b1;
                    end
                    khm_pkg::REQ_FADE:
                    begin
                        state_next = khm_pkg::S_LED;
                    end
                    khm_pkg::REQ_KEY:
                    begin
                        if (stat.key_ok)
                        begin
                            cmd.upd_key = 1'b1;
                            if (stat.changed)
                            begin
                                cmd.rd_en  = 1'b1;
                                cmd.rd_sel = khm_pkg::RD_TYPE;
                                state_next = khm_pkg::S_TYPE;
                            end
                        end
                    end
                    default:
                    begin
                        state_next = khm_pkg::S_IDLE;
                    end
                endcase
            end
            khm_pkg::S_TYPE:
            begin
                state_next = khm_pkg::S_IDLE;
                unique case (stat.tclass)
                    khm_pkg::TC_KEYBOARD:
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = khm_pkg::RD_KBD_MOD;
                        state_next = khm_pkg::S_MOD;
                    end
                    khm_pkg::TC_CONSUMER:
                    begin
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = khm_pkg::RD_CONS_CODE;
                        state_next = khm_pkg::S_EMIT_CONS;
                    end
                    khm_pkg::TC_MACRO:
                    begin
                        // macro release sends nothing
                        if (stat.cur)
                        begin
                            cmd.rd_en  = 1'b1;
                            cmd.rd_sel = khm_pkg::RD_COUNT;
                            state_next = khm_pkg::S_CNT;
                        end
                    end
                    default:
                    begin
                        state_next = khm_pkg::S_IDLE;
                    end
                endcase
            end
            khm_pkg::S_MOD:
            begin
                cmd.ld_mod = 1'b1;
                cmd.rd_en  = 1'b1;
                cmd.rd_sel = khm_pkg::RD_KBD_CODE;
                state_next = khm_pkg::S_EMIT_KBD;
            end
            khm_pkg::S_EMIT_KBD:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = stat.cur ? khm_pkg::EV_KBD_PRESS : khm_pkg::EV_KBD_RELEASE;
                    cmd.last   = 1'b1;
                    cmd.flip   = !stat.cur;
                    state_next = khm_pkg::S_IDLE;
                end
            end
            khm_pkg::S_EMIT_CONS:
            begin
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.kind     = stat.cur ? khm_pkg::EV_CONS_PRESS
                                            : khm_pkg::EV_CONS_RELEASE;
                    cmd.zero_mod = 1'b1;
                    cmd.last     = 1'b1;
                    cmd.flip     = !stat.cur;
                    state_next   = khm_pkg::S_IDLE;
                end
            end
            khm_pkg::S_CNT:
            begin
                cmd.ld_cnt = 1'b1;
                if (stat.cnt_zero)
                begin
                    state_next = khm_pkg::S_IDLE;
                end
                else
                begin
                    cmd.rd_en  = 1'b1;
                    cmd.rd_sel = khm_pkg::RD_MACRO_FIRST;
                    state_next = khm_pkg::S_MPRESS;
                end
            end
            khm_pkg::S_MPRESS:
            begin
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.kind     = khm_pkg::EV_KBD_PRESS;
                    cmd.zero_mod = 1'b1;
                    state_next   = khm_pkg::S_MREL;
                end
            end
            khm_pkg::S_MREL:
            begin
                if (stat.out_free)
                begin
                    cmd.emit     = 1'b1;
                    cmd.kind     = khm_pkg::EV_KBD_RELEASE;
                    cmd.zero_mod = 1'b1;
                    cmd.last     = stat.j_last;
                    if (stat.j_last)
                    begin
                        state_next = khm_pkg::S_IDLE;
                    end
                    else
                    begin
                        // fetch the next code while the release beat goes out
                        cmd.rd_en  = 1'b1;
                        cmd.rd_sel = khm_pkg::RD_MACRO_NEXT;
                        cmd.inc_j  = 1'b1;
                        state_next = khm_pkg::S_MPRESS;
                    end
                end
            end
            khm_pkg::S_LED:
            begin
                if (stat.out_free)
                begin
                    cmd.emit   = 1'b1;
                    cmd.kind   = khm_pkg::EV_LED_REPORT;
                    cmd.last   = 1'b1;
                    cmd.fade   = 1'b1;
                    state_next = khm_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = khm_pkg::S_IDLE;
            end
        endcase
    end

    // never load the output register while it still holds an untaken beat
    a_emit_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.emit |-> stat.out_free)
        else $error("beat emitted while output busy");

endmodule

`default_nettype wire

/* design/khm_dp.sv */
// ============================================================================
// khm_dp: datapath of the key to HID event mapper
// Item registers, key table, per-key state, LED levels and output register.
// ============================================================================
`default_nettype none

module khm_dp (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire khm_pkg::khm_cmd_t                   cmd,
    output khm_pkg::khm_stat_t                       stat,
    input  wire logic [1:0]                          in_req_type,
    input  wire logic [khm_pkg::KEY_W-1:0]           in_key_index,
    input  wire logic                                in_pressed,
    input  wire logic [khm_pkg::TADDR_W-1:0]         in_table_address,
    input  wire logic [khm_pkg::BYTE_W-1:0]          in_table_byte,
    input  wire logic                                cfg_we,
    input  wire logic [khm_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  wire logic [khm_pkg::LED_W-1:0]           cfg_data,
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    output logic [2:0]                               m_kind,
    output logic [khm_pkg::BYTE_W-1:0]               m_modifier,
    output logic [khm_pkg::BYTE_W-1:0]               m_key_code,
    output logic [khm_pkg::LEDS_W-1:0]               m_led_levels,
    output logic                                     m_last
);

    // item registers
    khm_pkg::req_type_t                 req_reg;
    logic [khm_pkg::KEY_W-1:0]          key_reg;
    logic                               cur_reg;
    logic [khm_pkg::TADDR_W-1:0]        taddr_reg;
    logic [khm_pkg::BYTE_W-1:0]         tbyte_reg;

    // config
    logic [khm_pkg::LED_W-1:0]          max_reg;
    logic [khm_pkg::LED_W-1:0]          glow_reg;

    // per-key state
    logic                               last_reg   [khm_pkg::NUM_KEYS];
    logic                               toggle_reg [khm_pkg::NUM_KEYS];
    logic [khm_pkg::LED_W-1:0]          led_reg    [khm_pkg::NUM_KEYS];

    logic [khm_pkg::BYTE_W-1:0]         mod_reg;
    logic [khm_pkg::CNT_W-1:0]          cnt_reg;
    logic [khm_pkg::CNT_W-1:0]          j_reg;

    logic                               out_valid_reg;
    khm_pkg::event_kind_t               out_kind_reg;
    logic [khm_pkg::BYTE_W-1:0]         out_mod_reg;
    logic [khm_pkg::BYTE_W-1:0]         out_code_reg;
    logic [khm_pkg::LEDS_W-1:0]         out_leds_reg;
    logic                               out_last_reg;

    logic [khm_pkg::BYTE_W-1:0]         ram_q;
    logic [khm_pkg::ADDR_W-1:0]         row_base;
    logic [khm_pkg::OFF_W-1:0]          rd_off;
    logic [khm_pkg::ADDR_W-1:0]         rd_addr;
    logic                               tbl_we;
    logic                               key_ok;
    logic                               tog;
    logic [khm_pkg::CNT_W-1:0]          cnt_cap;
    logic [khm_pkg::LEDS_W-1:0]         leds_packed;

    assign key_ok   = 32'(key_reg) < khm_pkg::NUM_KEYS;
    assign tog      = toggle_reg[key_reg];
    assign row_base = khm_pkg::ADDR_W'(32'(key_reg) * khm_pkg::ROW_BYTES);
    assign rd_addr  = row_base + khm_pkg::ADDR_W'(rd_off);
    assign tbl_we   = cmd.tbl_wr && (32'(taddr_reg) < khm_pkg::TABLE_SIZE);
    assign cnt_cap  = (ram_q > khm_pkg::BYTE_W'(khm_pkg::MACRO_CAP)) ?
                      khm_pkg::CNT_W'(khm_pkg::MACRO_CAP) : khm_pkg::CNT_W'(ram_q);

    always_comb
    begin
        unique case (cmd.rd_sel)
            khm_pkg::RD_TYPE:        rd_off = khm_pkg::OFF_TYPE;
            khm_pkg::RD_KBD_MOD:     rd_off = tog ? khm_pkg::OFF_KBD1_MOD
                                                  : khm_pkg::OFF_KBD0_MOD;
            khm_pkg::RD_KBD_CODE:    rd_off = tog ? khm_pkg::OFF_KBD1_CODE
                                                  : khm_pkg::OFF_KBD0_CODE;
            khm_pkg::RD_CONS_CODE:   rd_off = tog ? khm_pkg::OFF_CONS1
                                                  : khm_pkg::OFF_CONS0;
            khm_pkg::RD_COUNT:       rd_off = khm_pkg::OFF_COUNT;
            khm_pkg::RD_MACRO_FIRST: rd_off = khm_pkg::OFF_MACRO0;
            khm_pkg::RD_MACRO_NEXT:  rd_off = khm_pkg::OFF_MACRO_NXT
                                              + khm_pkg::OFF_W'(j_reg);
            default:                 rd_off = khm_pkg::OFF_TYPE;
        endcase
    end

    always_comb
    begin
        leds_packed = '0;
        for (int i = 0; i < khm_pkg::NUM_KEYS; i++)
        begin
            if (i < khm_pkg::REPORT_N)
            begin
                leds_packed[i*khm_pkg::LED_W +: khm_pkg::LED_W] = led_reg[i];
            end
        end
    end

    khm_ram #(
        .WIDTH (khm_pkg::BYTE_W),
        .DEPTH (khm_pkg::TABLE_SIZE)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (khm_pkg::ADDR_W'(taddr_reg)),
        .wdata (tbyte_reg),
        .re    (cmd.rd_en),
        .raddr (rd_addr),
        .rdata (ram_q)
    );

    // status
    always_comb
    begin
        stat.req      = req_reg;
        stat.key_ok   = key_ok;
        stat.changed  = cur_reg != last_reg[key_reg];
        stat.cur      = cur_reg;
        if (ram_q == khm_pkg::KEYBOARD)
        begin
            stat.tclass = khm_pkg::TC_KEYBOARD;
        end
        else if (ram_q == khm_pkg::CONSUMER)
        begin
            stat.tclass = khm_pkg::TC_CONSUMER;
        end
        else if (ram_q == khm_pkg::MACRO)
        begin
            stat.tclass = khm_pkg::TC_MACRO;
        end
        else
        begin
            stat.tclass = khm_pkg::TC_OTHER;
        end
        stat.cnt_zero = cnt_cap == '0;
        stat.j_last   = (j_reg + khm_pkg::CNT_W'(1)) == cnt_reg;
        stat.out_free = !out_valid_reg || m_tready;
    end

    // item and work registers (payload, no reset)
    always_ff @(posedge clk)
    begin
        if (cmd.ld_item)
        begin
            req_reg   <= khm_pkg::req_type_t'(in_req_type);
            key_reg   <= in_key_index;
            cur_reg   <= in_pressed;
            taddr_reg <= in_table_address;
            tbyte_reg <= in_table_byte;
        end
        if (cmd.ld_mod)
        begin
            mod_reg <= ram_q;
        end
        if (cmd.ld_cnt)
        begin
            cnt_reg <= cnt_cap;
            j_reg   <= '0;
        end
        else if (cmd.inc_j)
        begin
            j_reg <= j_reg + khm_pkg::CNT_W'(1);
        end
        if (cmd.emit)
        begin
            out_kind_reg <= cmd.kind;
            out_last_reg <= cmd.last;
            if (cmd.kind == khm_pkg::EV_LED_REPORT)
            begin
                out_mod_reg  <= '0;
                out_code_reg <= '0;
                out_leds_reg <= leds_packed;
            end
            else
            begin
                out_mod_reg  <= cmd.zero_mod ? '0 : mod_reg;
                out_code_reg <= ram_q;
                out_leds_reg <= '0;
            end
        end
    end

    // config, key state, LED levels, output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_reg       <= khm_pkg::LED_MAX_RESET;
            glow_reg      <= khm_pkg::LED_GLOW_RESET;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < khm_pkg::NUM_KEYS; i++)
            begin
                last_reg[i]   <= 1'b0;
                toggle_reg[i] <= 1'b0;
                led_reg[i]    <= (khm_pkg::NUM_KEYS > 1 && i == 1) ?
                                 khm_pkg::LED_MAX_RESET : '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    khm_pkg::CFG_LED_MAX:  max_reg  <= cfg_data;
                    khm_pkg::CFG_LED_GLOW: glow_reg <= cfg_data;
                    default: ;
                endcase
            end
            if (cmd.upd_key)
            begin
                last_reg[key_reg] <= cur_reg;
                if (cur_reg)
                begin
                    led_reg[key_reg] <= max_reg;
                end
            end
            if (cmd.flip)
            begin
                toggle_reg[key_reg] <= !tog;
            end
            if (cmd.fade)
            begin
                for (int i = 0; i < khm_pkg::NUM_KEYS; i++)
                begin
                    if (led_reg[i] > glow_reg)
                    begin
                        led_reg[i] <= led_reg[i] - khm_pkg::LED_W'(1);
                    end
                end
            end
            if (cmd.emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign m_tvalid     = out_valid_reg;
    assign m_kind       = out_kind_reg;
    assign m_modifier   = out_mod_reg;
    assign m_key_code   = out_code_reg;
    assign m_led_levels = out_leds_reg;
    assign m_last       = out_last_reg;

    a_rw_apart: assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.tbl_wr && cmd.rd_en))
        else $error("table write and read in one cycle");

    a_j_bound: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.inc_j |-> ((j_reg + khm_pkg::CNT_W'(1)) < cnt_reg))
        else $error("macro index past stored count");

endmodule

`default_nettype wire

/* design/key_to_hid_event_mapper_unit.sv */
// ============================================================================
// key_to_hid_event_mapper_unit: key level samples to HID events
// Top level: stream ports, configuration port, sequencer and datapath.
// ============================================================================
// One item is in work at a time; s_tready is high only while the sequencer
// is idle. A table write or an unchanged key sample ends at dispatch, a fade
// tick adds one LED report beat, a keyboard item reads type, modifier and
// code, a consumer item type and code, a macro press with n codes (n capped
// at 10) type and count, then a press and a release beat per code: the key
// table is one memory with a registered read port, so each byte fetched is
// its own step, and the macro loop fetches the next code while the release
// beat of the current one goes out. Every beat is held in an output register,
// so a stalled consumer just stretches the item by the stall. The key table
// has no reset: each row must be written before its key is sampled.
// ============================================================================
`default_nettype none

module key_to_hid_event_mapper_unit (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    // slave stream: one request per beat
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // [2:0] key_index, [3] pressed, [10:4] table_address, [18:11] table_byte,
    // [23:19] zero
    input  wire logic [khm_pkg::S_DATA_W-1:0]      s_tdata,
    // [1:0] req_type
    input  wire logic [1:0]                        s_tuser,
    // master stream: one event per beat
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // [7:0] modifier, [15:8] key_code, [79:16] led_levels
    output logic [khm_pkg::M_DATA_W-1:0]           m_tdata,
    // [2:0] event_kind
    output logic [2:0]                             m_tuser,
    // last_of_run
    output logic                                   m_tlast,
    // configuration: 0 led_max_level, 1 led_glow_level
    input  wire logic                              cfg_we,
    input  wire logic [khm_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  wire logic [khm_pkg::LED_W-1:0]         cfg_data
);

    khm_pkg::khm_cmd_t  cmd;
    khm_pkg::khm_stat_t stat;

    logic [khm_pkg::BYTE_W-1:0] modifier;
    logic [khm_pkg::BYTE_W-1:0] key_code;
    logic [khm_pkg::LEDS_W-1:0] led_levels;

    khm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    khm_dp u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .stat             (stat),
        .in_req_type      (s_tuser),
        .in_key_index     (s_tdata[2:0]),
        .in_pressed       (s_tdata[3]),
        .in_table_address (s_tdata[10:4]),
        .in_table_byte    (s_tdata[18:11]),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .m_tvalid         (m_tvalid),
        .m_tready         (m_tready),
        .m_kind           (m_tuser),
        .m_modifier       (modifier),
        .m_key_code       (key_code),
        .m_led_levels     (led_levels),
        .m_last           (m_tlast)
    );

    assign m_tdata = {led_levels, key_code, modifier};

    // one item at a time: an accepted beat closes the input until it is done
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input reopened right after accept");

endmodule

`default_nettype wire

/* bench/tb.sv */
// ----------------------------------------------------------------------------
// tb: self-checking bench for key_to_hid_event_mapper_unit
// Loads the whole key table, runs a directed pass over key types, toggles,
// macro counts and fade ticks, then random request streams under several LED
// settings. Every request beat accepted on the slave side goes into a predictor
// that mirrors the table, key levels, toggles and LED levels. Every event beat
// on the master side is checked against the oldest predicted event.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    // req_type 3 is not a request; the block must drop it
    localparam logic [1:0] REQ_UNUSED  = 2'd3;
    localparam int MACRO_LIMIT = (khm_pkg::MAX_MACRO_CODES < khm_pkg::ROW_BYTES - 2) ?
                                 khm_pkg::MAX_MACRO_CODES : khm_pkg::ROW_BYTES - 2;
    localparam int LONG_HOLD_CYCLES = 400;
    localparam int SETTLE_CYCLES    = 30;  // longest item with no event is an empty macro press
    localparam int PHASE_ITEMS      = 90;

    typedef struct {
        logic [1:0] req;
        logic [2:0] key;
        logic       pressed;
        logic [6:0] addr;
        logic [7:0] data;
    } hid_request_t;

    typedef struct {
        khm_pkg::event_kind_t kind;
        logic [7:0]           modifier;
        logic [7:0]           code;
        logic [63:0]          leds;
        logic                 end_of_run;
    } hid_event_t;

    // ------------------------------------------------------------------------
    // Event predictor and queue of events still owed by the block
    // ------------------------------------------------------------------------
    class hid_event_scoreboard;
        logic [7:0] key_rows [khm_pkg::TABLE_SIZE];
        logic       last_lvl [khm_pkg::NUM_KEYS];
        logic       toggle   [khm_pkg::NUM_KEYS];
        logic [7:0] led_lvl  [khm_pkg::NUM_KEYS];
        logic [7:0] led_max;
        logic [7:0] led_glow;
        hid_event_t owed_events[$];
        int         errors;

        function new();
            foreach (key_rows[i]) key_rows[i] = '0;
            for (int i = 0; i < khm_pkg::NUM_KEYS; i++)
            begin
                last_lvl[i] = 1'b0;
                toggle[i]   = 1'b0;
                led_lvl[i]  = '0;
            end
            led_max  = khm_pkg::LED_MAX_RESET;
            led_glow = khm_pkg::LED_GLOW_RESET;
            led_lvl[1] = khm_pkg::LED_MAX_RESET;
            errors = 0;
        endfunction

        function int pending();
            return owed_events.size();
        endfunction

        function void write_reg(logic [khm_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
            if (idx == khm_pkg::CFG_LED_MAX)
                led_max = val;
            else if (idx == khm_pkg::CFG_LED_GLOW)
                led_glow = val;
        endfunction

        function logic [7:0] row_byte(int k, int off);
            return key_rows[k * khm_pkg::ROW_BYTES + off];
        endfunction

        function hid_event_t ev(khm_pkg::event_kind_t kind, logic [7:0] m,
                                logic [7:0] c, logic [63:0] l);
            hid_event_t e;
            e.kind       = kind;
            e.modifier   = m;
            e.code       = c;
            e.leds       = l;
            e.end_of_run = 1'b0;
            return e;
        endfunction

        function void accept_request(hid_request_t r);
            hid_event_t  run[$];
            logic [7:0]  ktype;
            logic        t;
            int          k;
            int          cnt;
            logic [7:0]  c;
            logic [63:0] leds;
            k = r.key;
            case (r.req)
                khm_pkg::REQ_WRITE:
                    if (r.addr < khm_pkg::TABLE_SIZE)
                        key_rows[r.addr] = r.data;
                khm_pkg::REQ_FADE:
                begin
                    leds = '0;
                    for (int i = 0; i < khm_pkg::NUM_KEYS && i < 8; i++)
                        leds[8*i +: 8] = led_lvl[i];
                    run.push_back(ev(khm_pkg::EV_LED_REPORT, '0, '0, leds));
                    for (int i = 0; i < khm_pkg::NUM_KEYS; i++)
                        if (led_lvl[i] > led_glow)
                            led_lvl[i] = led_lvl[i] - 8'd1;
                end
                khm_pkg::REQ_KEY:
                begin
                    if (r.pressed != last_lvl[k])
                    begin
                        ktype = row_byte(k, 0);
                        t = toggle[k];
                        last_lvl[k] = r.pressed;
                        if (r.pressed)
                        begin
                            if (ktype == khm_pkg::KEYBOARD)
                                run.push_back(ev(khm_pkg::EV_KBD_PRESS,
                                                 row_byte(k, t ? 3 : 1),
                                                 row_byte(k, t ? 4 : 2), '0));
                            else if (ktype == khm_pkg::CONSUMER)
                                run.push_back(ev(khm_pkg::EV_CONS_PRESS, '0,
                                                 row_byte(k, t ? 2 : 1), '0));
                            else if (ktype == khm_pkg::MACRO)
                            begin
                                cnt = row_byte(k, 1);
                                if (cnt > MACRO_LIMIT)
                                    cnt = MACRO_LIMIT;
                                for (int j = 0; j < cnt; j++)
                                begin
                                    c = row_byte(k, 2 + j);
                                    run.push_back(ev(khm_pkg::EV_KBD_PRESS, '0, c, '0));
                                    run.push_back(ev(khm_pkg::EV_KBD_RELEASE, '0, c, '0));
                                end
                            end
                            led_lvl[k] = led_max;
                        end
                        else if (ktype == khm_pkg::KEYBOARD)
                        begin
                            run.push_back(ev(khm_pkg::EV_KBD_RELEASE, row_byte(k, t ? 3 : 1),
                                             row_byte(k, t ? 4 : 2), '0));
                            toggle[k] = ~t;
                        end
                        else if (ktype == khm_pkg::CONSUMER)
                        begin
                            run.push_back(ev(khm_pkg::EV_CONS_RELEASE, '0,
                                             row_byte(k, t ? 2 : 1), '0));
                            toggle[k] = ~t;
                        end
                    end
                    else if (last_lvl[k])
                        led_lvl[k] = led_max;
                end
                default: ;
            endcase
            if (run.size() > 0)
                run[run.size() - 1].end_of_run = 1'b1;
            foreach (run[i]) owed_events.push_back(run[i]);
        endfunction

        task report(string msg);
            if (errors < 40)
                $display("tb: mismatch: %s", msg);
            errors++;
        endtask

        task check_event(logic [2:0] kind, logic [7:0] m, logic [7:0] c,
                         logic [63:0] l, logic eor);
            hid_event_t e;
            if (owed_events.size() == 0)
            begin
                report($sformatf("event beat kind %0d with nothing expected", kind));
                return;
            end
            e = owed_events.pop_front();
            if (kind !== e.kind)
                report($sformatf("kind %0d, expected %0d", kind, e.kind));
            if (m !== e.modifier)
                report($sformatf("modifier %02h, expected %02h", m, e.modifier));
            if (c !== e.code)
                report($sformatf("key_code %02h, expected %02h", c, e.code));
            if (l !== e.leds)
                report($sformatf("led_levels %016h, expected %016h", l, e.leds));
            if (eor !== e.end_of_run)
                report($sformatf("tlast %0b, expected %0b", eor, e.end_of_run));
        endtask
    endclass

    // ------------------------------------------------------------------------
    // Clock, DUT signals
    // ------------------------------------------------------------------------
    logic clk = 1'b0;
    logic rst_n;

    logic                           s_tvalid;
    logic                           s_tready;
    logic [khm_pkg::S_DATA_W-1:0]   s_tdata;
    logic [1:0]                     s_tuser;
    logic                           m_tvalid;
    logic                           m_tready;
    logic [khm_pkg::M_DATA_W-1:0]   m_tdata;
    logic [2:0]                     m_tuser;
    logic                           m_tlast;
    logic                           cfg_we;
    logic [khm_pkg::CFG_IDX_W-1:0]  cfg_index;
    logic [khm_pkg::LED_W-1:0]      cfg_data;

    // calm: no idling on either side; long_hold: receiver backs off for a
    // long stretch, cleared by the receiver once it is over
    logic calm = 1'b0;
    logic long_hold = 1'b0;

    hid_event_scoreboard sb = new();

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    key_to_hid_event_mapper_unit DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),     // key, pressed, address, byte from bit 0 up
        .s_tuser   (s_tuser),     // req_type
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),     // modifier, key_code, led_levels from bit 0 up
        .m_tuser   (m_tuser),     // event_kind
        .m_tlast   (m_tlast),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // ------------------------------------------------------------------------
    // Event side: checker and back-pressure
    // ------------------------------------------------------------------------
    // Values read here are the ones from before the edge, so the check sees
    // exactly what the handshake saw.
    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
            sb.check_event(m_tuser, m_tdata[7:0], m_tdata[15:8], m_tdata[79:16], m_tlast);
    end

    // Ready alternates between random stall bursts and ready stretches. A long
    // hold lets the block fill up while the sender keeps offering requests.
    initial
    begin
        m_tready = 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (calm)
            begin
                m_tready <= 1'b1;
                @(posedge clk);
            end
            else if (long_hold)
            begin
                m_tready <= 1'b0;
                repeat (LONG_HOLD_CYCLES) @(posedge clk);
                long_hold = 1'b0;
            end
            else if ($urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 19)) @(posedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 40)) @(posedge clk);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Request side
    // ------------------------------------------------------------------------
    function automatic hid_request_t make_req(logic [1:0] req, int k, logic p,
                                              int addr, int data);
        hid_request_t r;
        r.req     = req;
        r.key     = 3'(k);
        r.pressed = p;
        r.addr    = 7'(addr);
        r.data    = 8'(data);
        return r;
    endfunction

    // Don't-care fields are randomized too, so every tdata bit but the zero [23:19] toggles.
    function automatic hid_request_t random_req();
        hid_request_t r;
        int sel;
        int off;
        r = make_req(khm_pkg::REQ_KEY, $urandom_range(0, 7), 1'($urandom),
                     $urandom_range(0, 127), $urandom_range(0, 255));
        sel = $urandom_range(0, 99);
        if (sel < 50)
        begin
            // mostly real edges, sometimes a repeated level (hold)
            if ($urandom_range(0, 3) == 0)
                r.pressed = sb.last_lvl[r.key];
            else
                r.pressed = ~sb.last_lvl[r.key];
        end
        else if (sel < 80)
        begin
            r.req = khm_pkg::REQ_WRITE;
            if ($urandom_range(0, 9) == 0)
                r.addr = 7'($urandom_range(khm_pkg::TABLE_SIZE, 127));
            else
                r.addr = 7'($urandom_range(0, khm_pkg::TABLE_SIZE - 1));
            off = r.addr % khm_pkg::ROW_BYTES;
            if (off == 0)
            begin
                case ($urandom_range(0, 4))
                    0:       r.data = khm_pkg::KEYBOARD;
                    1:       r.data = khm_pkg::CONSUMER;
                    2, 3:    r.data = khm_pkg::MACRO;
                    default: ;
                endcase
            end
            else if (off == 1 && $urandom_range(0, 1) == 1)
                r.data = 8'($urandom_range(0, 12));   // macro counts near the cap
        end
        else if (sel < 95)
            r.req = khm_pkg::REQ_FADE;
        else
            r.req = REQ_UNUSED;
        return r;
    endfunction

    // Leaves tvalid high on return: the caller either chains the next beat in
    // this same step or drops valid through idle_tx.
    task automatic send_req(hid_request_t r);
        s_tvalid <= 1'b1;
        s_tdata  <= {5'b0, r.data, r.addr, r.pressed, r.key};
        s_tuser  <= r.req;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
        sb.accept_request(r);
    endtask

    task automatic idle_tx(int n);
        s_tvalid <= 1'b0;
        repeat (n) @(posedge clk);
    endtask

    task automatic tx_gap();
        if (!calm && $urandom_range(0, 3) == 0)
            idle_tx($urandom_range(1, 19));
    endtask

    task automatic sample_key(int k, logic p);
        send_req(make_req(khm_pkg::REQ_KEY, k, p, $urandom_range(0, 127),
                          $urandom_range(0, 255)));
        tx_gap();
    endtask

    task automatic fade_tick();
        send_req(make_req(khm_pkg::REQ_FADE, $urandom_range(0, 7), 1'($urandom),
                          $urandom_range(0, 127), $urandom_range(0, 255)));
        tx_gap();
    endtask

    task automatic table_write(int addr, int data);
        send_req(make_req(khm_pkg::REQ_WRITE, $urandom_range(0, 7), 1'($urandom),
                          addr, data));
        tx_gap();
    endtask

    // Drain: no beat in flight, every owed event out, then a settle wait for
    // any trailing eventless item before touching registers.
    task automatic drain();
        idle_tx(1);
        while (sb.pending() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [khm_pkg::CFG_IDX_W-1:0] idx, logic [7:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        sb.write_reg(idx, val);
        cfg_we <= 1'b0;
        @(posedge clk);
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial
    begin
        logic [7:0] img [khm_pkg::TABLE_SIZE];
        logic [7:0] max_set  [4];
        logic [7:0] glow_set [4];

        rst_n     = 1'b0;
        s_tvalid  = 1'b0;
        s_tdata   = '0;
        s_tuser   = '0;
        cfg_we    = 1'b0;
        cfg_index = '0;
        cfg_data  = '0;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Full table load, so no row byte is ever read unwritten.
        // key 0 keyboard with all-zero / all-ones code pairs, key 1 consumer,
        // key 2 macro at the cap, key 3 count above the cap, key 4 empty
        // macro, key 5 unknown type, key 6 keyboard, key 7 single-code macro
        foreach (img[i]) img[i] = 8'($urandom_range(0, 255));
        img[0*khm_pkg::ROW_BYTES + 0] = khm_pkg::KEYBOARD;
        img[0*khm_pkg::ROW_BYTES + 1] = 8'h00;
        img[0*khm_pkg::ROW_BYTES + 2] = 8'h00;
        img[0*khm_pkg::ROW_BYTES + 3] = 8'hFF;
        img[0*khm_pkg::ROW_BYTES + 4] = 8'hFF;
        img[1*khm_pkg::ROW_BYTES + 0] = khm_pkg::CONSUMER;
        img[1*khm_pkg::ROW_BYTES + 1] = 8'hFF;
        img[1*khm_pkg::ROW_BYTES + 2] = 8'h00;
        img[2*khm_pkg::ROW_BYTES + 0] = khm_pkg::MACRO;
        img[2*khm_pkg::ROW_BYTES + 1] = 8'(MACRO_LIMIT);
        img[3*khm_pkg::ROW_BYTES + 0] = khm_pkg::MACRO;
        img[3*khm_pkg::ROW_BYTES + 1] = 8'hFF;
        img[4*khm_pkg::ROW_BYTES + 0] = khm_pkg::MACRO;
        img[4*khm_pkg::ROW_BYTES + 1] = 8'h00;
        img[5*khm_pkg::ROW_BYTES + 0] = 8'hFF;
        img[6*khm_pkg::ROW_BYTES + 0] = khm_pkg::KEYBOARD;
        img[7*khm_pkg::ROW_BYTES + 0] = khm_pkg::MACRO;
        img[7*khm_pkg::ROW_BYTES + 1] = 8'h01;
        for (int a = 0; a < khm_pkg::TABLE_SIZE; a++)
            table_write(a, img[a]);

        // Directed pass at reset register values
        fade_tick();                       // reset LED levels, key 1 lit
        sample_key(0, 1'b1);               // keyboard, toggle 0
        sample_key(0, 1'b0);
        sample_key(0, 1'b1);               // keyboard, toggle 1
        sample_key(0, 1'b0);
        sample_key(1, 1'b1);               // consumer
        sample_key(1, 1'b1);               // hold: LED refresh only
        sample_key(1, 1'b0);
        sample_key(1, 1'b1);
        sample_key(1, 1'b0);
        sample_key(2, 1'b1);               // full macro burst
        sample_key(2, 1'b0);               // macro release: silent
        sample_key(3, 1'b1);               // count capped
        sample_key(3, 1'b0);
        sample_key(4, 1'b1);               // empty macro: no events
        sample_key(4, 1'b0);
        sample_key(5, 1'b1);               // unknown type: silent, LED still set
        sample_key(5, 1'b1);
        fade_tick();
        sample_key(5, 1'b0);
        sample_key(7, 1'b1);
        sample_key(7, 1'b0);
        table_write(khm_pkg::TABLE_SIZE, 8'hAA);    // out of range: dropped
        table_write(127, 8'h55);
        send_req(make_req(REQ_UNUSED, 7, 1'b1, 127, 255));
        tx_gap();
        fade_tick();

        // Register settings per random phase, extremes first
        max_set[0]  = 8'hFF;                     glow_set[0] = 8'h00;
        max_set[1]  = 8'h00;                     glow_set[1] = 8'hFF;
        max_set[2]  = 8'($urandom_range(0, 255)); glow_set[2] = 8'($urandom_range(0, 255));
        max_set[3]  = 8'($urandom_range(2, 255)); glow_set[3] = 8'($urandom_range(0, 40));

        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            write_reg(khm_pkg::CFG_LED_MAX, max_set[ph]);
            write_reg(khm_pkg::CFG_LED_GLOW, glow_set[ph]);
            if (ph == 1)
            begin
                // Receiver backs off while macro bursts keep coming: the
                // output register fills and s_tready has to drop.
                long_hold = 1'b1;
                send_req(make_req(khm_pkg::REQ_WRITE, 0, 1'b0,
                                  2*khm_pkg::ROW_BYTES + 0, khm_pkg::MACRO));
                send_req(make_req(khm_pkg::REQ_WRITE, 0, 1'b0,
                                  2*khm_pkg::ROW_BYTES + 1, MACRO_LIMIT));
                for (int n = 0; n < 6; n++)
                    send_req(make_req(khm_pkg::REQ_KEY, 2, 1'(n % 2),
                                      $urandom_range(0, 127), $urandom_range(0, 255)));
            end
            if (ph == 3)
                calm = 1'b1;
            repeat (PHASE_ITEMS)
            begin
                send_req(random_req());
                tx_gap();
            end
        end

        drain();
        if (sb.errors == 0)
            $display("tb: PASS");
        else
            $display("tb: FAIL");
        $finish;
    end

    // Watchdog, far above the slowest legal run
    initial
    begin
        #2000000;
        $display("tb: FAIL");
        $finish;
    end

endmodule

`default_nettype wire
